// ----- sv/srst_pkg.sv -----
// ----------------------------------------------------------------------------
// srst_pkg
// types and constants shared by the retransmit slot tracker files
// ----------------------------------------------------------------------------
package srst_pkg;

    localparam int SLOTS    = 32;
    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int CNT_W    = $clog2(SLOTS + 1);
    localparam int TSN_W    = 32;
    localparam int LIM_W    = 8;
    localparam int ENTRY_W  = TSN_W + 2 * LIM_W;

    typedef enum logic [2:0] {
        OP_RECORD     = 3'd0,
        OP_SACK_CUM   = 3'd1,
        OP_SACK_GAP   = 3'd2,
        OP_RETRANSMIT = 3'd3,
        OP_FREE_ALL   = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        KIND_RECORD = 2'd0,
        KIND_RESEND = 2'd1,
        KIND_DONE   = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [2:0]  operation;
        logic [31:0] sent_tsn;
        logic [7:0]  max_resends;
        logic [31:0] cum_tsn;
        logic        has_gaps;
        logic [15:0] gap_start;
        logic [15:0] gap_end;
    } t_req;

    typedef struct packed {
        t_kind       kind;
        logic [4:0]  slot;
        logic [31:0] entry_tsn;
        logic        evicted;
        logic [5:0]  resend_total;
        logic        last;
    } t_res;

    typedef struct packed {
        logic [TSN_W-1:0] tsn;
        logic [LIM_W-1:0] limit;
        logic [LIM_W-1:0] resends;
    } t_entry;

    function automatic logic at_or_before(logic [TSN_W-1:0] tsn, logic [TSN_W-1:0] ref_tsn);
        logic [TSN_W-1:0] d;
        d = tsn - ref_tsn;
        return (d == '0) || d[TSN_W-1];
    endfunction

endpackage

// ----- sv/srst_if.sv -----
// ----------------------------------------------------------------------------
// srst_req_if / srst_res_if
// valid/ready channels carrying request and result beats
// ----------------------------------------------------------------------------
interface srst_req_if import srst_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface srst_res_if import srst_pkg::*; ();
    logic valid;
    logic ready;
    t_res data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/srst_ram.sv -----
// ----------------------------------------------------------------------------
// srst_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module srst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/sack_retransmit_slot_tracker_top.sv -----
// ----------------------------------------------------------------------------
// sack_retransmit_slot_tracker_top
// ring of retransmit slots tracking sent fragments by tsn
//
// i_req carries one operation per beat: record, cumulative sack, gap block,
// retransmit scan or free all. o_res carries result beats; last marks the
// final beat of an operation.
// a record's result shows in the cycle after its beat.
// sack_cum, sack_gap and retransmit walk every slot through the single read
// port of the slot memory, one slot per cycle while no resend is held, and a
// retransmit scan ends with a finishing beat. free_all, an idle retransmit,
// a zero-limit record and unknown codes give no result.
// i_req.ready is high while no scan runs and the result register is free or
// being emptied in the same cycle.
// a stalled o_res holds its beat; a scan that must emit a resend waits on
// that slot until the result register frees up.
// reset clears all valid bits, the write head, the stored ack and the
// pending flag; memory contents are read only behind a set valid bit.
// ----------------------------------------------------------------------------
module sack_retransmit_slot_tracker_top import srst_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    srst_req_if.sink      i_req,
    srst_res_if.source    o_res
);

    t_state              r_state, n_state;
    t_op                 r_op;
    logic [SLOTS-1:0]    r_valid;
    logic [SLOT_W-1:0]   r_head;
    logic [SLOT_W-1:0]   r_idx;
    logic [TSN_W-1:0]    r_acked;
    logic [TSN_W-1:0]    r_lo;
    logic [TSN_W-1:0]    r_hi;
    logic                r_pending;
    logic [CNT_W-1:0]    r_count;
    logic                r_out_valid, n_out_valid;
    t_res                r_out, n_out;

    logic                w_acc;
    logic                w_out_free;
    logic                w_start;
    logic                w_rec;
    logic                w_last_idx;
    logic                w_emit;
    logic                w_hold;
    logic                w_clear;
    logic                w_aob;
    logic                w_in_gap;
    logic                w_can_resend;
    logic                ram_we;
    logic                ram_re;
    logic [SLOT_W-1:0]   ram_waddr;
    logic [SLOT_W-1:0]   ram_raddr;
    t_entry              ram_wdata;
    t_entry              ram_rdata;

    srst_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign w_out_free  = !r_out_valid || o_res.ready;
    assign i_req.ready = (r_state == ST_IDLE) && w_out_free;
    assign w_acc       = i_req.valid && i_req.ready;
    assign w_rec       = w_acc && (i_req.data.operation == OP_RECORD)
                         && (i_req.data.max_resends != '0);
    assign w_start     = w_acc && ((i_req.data.operation == OP_SACK_CUM)
                         || (i_req.data.operation == OP_SACK_GAP)
                         || ((i_req.data.operation == OP_RETRANSMIT) && r_pending));
    assign w_last_idx  = (r_idx == SLOT_W'(SLOTS - 1));

    // slot evaluation on the registered entry read for the current slot
    assign w_aob        = at_or_before(ram_rdata.tsn, r_acked);
    assign w_in_gap     = (ram_rdata.tsn >= r_lo) && (ram_rdata.tsn <= r_hi);
    assign w_can_resend = ram_rdata.resends < ram_rdata.limit;
    assign w_emit       = (r_state == ST_SCAN) && (r_op == OP_RETRANSMIT) && r_valid[r_idx]
                          && !w_aob && w_can_resend;
    assign w_hold       = w_emit && !w_out_free;

    always_comb begin
        w_clear = 1'b0;
        if ((r_state == ST_SCAN) && r_valid[r_idx]) begin
            case (r_op)
                OP_SACK_CUM:   w_clear = w_aob;
                OP_SACK_GAP:   w_clear = w_in_gap;
                OP_RETRANSMIT: w_clear = !w_emit;
                default:       w_clear = 1'b0;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_start) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!w_hold && w_last_idx) begin
                    n_state = (r_op == OP_RETRANSMIT) ? ST_DONE : ST_IDLE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // memory control and result register
    always_comb begin
        ram_we      = 1'b0;
        ram_waddr   = r_idx;
        ram_wdata   = ram_rdata;
        ram_re      = 1'b0;
        ram_raddr   = r_idx + SLOT_W'(1);
        n_out_valid = r_out_valid && !o_res.ready;
        n_out       = r_out;
        case (r_state)
            ST_IDLE: begin
                ram_raddr = '0;
                ram_re    = w_start;
                if (w_rec) begin
                    ram_we            = 1'b1;
                    ram_waddr         = r_head;
                    ram_wdata.tsn     = i_req.data.sent_tsn;
                    ram_wdata.limit   = i_req.data.max_resends;
                    ram_wdata.resends = '0;
                    n_out_valid        = 1'b1;
                    n_out.kind         = KIND_RECORD;
                    n_out.slot         = 5'(r_head);
                    n_out.entry_tsn    = i_req.data.sent_tsn;
                    n_out.evicted      = r_valid[r_head];
                    n_out.resend_total = '0;
                    n_out.last         = 1'b1;
                end
            end
            ST_SCAN: begin
                ram_re = !w_hold && !w_last_idx;
                if (w_emit && !w_hold) begin
                    ram_we             = 1'b1;
                    ram_wdata.resends  = ram_rdata.resends + LIM_W'(1);
                    n_out_valid        = 1'b1;
                    n_out.kind         = KIND_RESEND;
                    n_out.slot         = 5'(r_idx);
                    n_out.entry_tsn    = ram_rdata.tsn;
                    n_out.evicted      = 1'b0;
                    n_out.resend_total = '0;
                    n_out.last         = 1'b0;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_out_valid        = 1'b1;
                    n_out.kind         = KIND_DONE;
                    n_out.slot         = '0;
                    n_out.entry_tsn    = '0;
                    n_out.evicted      = 1'b0;
                    n_out.resend_total = 6'(r_count);
                    n_out.last         = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_valid     <= '0;
            r_head      <= '0;
            r_acked     <= '0;
            r_pending   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (w_rec) begin
                r_valid[r_head] <= 1'b1;
                r_head <= (r_head == SLOT_W'(SLOTS - 1)) ? '0 : r_head + SLOT_W'(1);
            end
            if (w_clear) begin
                r_valid[r_idx] <= 1'b0;
            end
            if (w_acc) begin
                case (i_req.data.operation)
                    OP_SACK_CUM: begin
                        r_acked <= i_req.data.cum_tsn;
                        if (i_req.data.has_gaps) begin
                            r_pending <= 1'b1;
                        end
                    end
                    OP_RETRANSMIT: r_pending <= 1'b0;
                    OP_FREE_ALL: begin
                        r_valid <= '0;
                        r_head  <= '0;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (w_start) begin
            r_op    <= t_op'(i_req.data.operation);
            r_idx   <= '0;
            r_count <= '0;
            r_lo    <= r_acked + TSN_W'(i_req.data.gap_start);
            r_hi    <= r_acked + TSN_W'(i_req.data.gap_end);
        end else if ((r_state == ST_SCAN) && !w_hold) begin
            r_idx <= r_idx + SLOT_W'(1);
            if (w_emit) begin
                r_count <= r_count + CNT_W'(1);
            end
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

endmodule

// ----- sv/srst_checker.sv -----
// ----------------------------------------------------------------------------
// srst_checker
// port-level checks of the retransmit slot tracker, bound to the top level
// ----------------------------------------------------------------------------
module srst_checker import srst_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_valid,
    input logic        i_req_ready,
    input logic [2:0]  i_req_op,
    input logic [7:0]  i_req_limit,
    input logic        i_res_valid,
    input logic        i_res_ready,
    input t_res        i_res_data
);

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_data))
        else $error("result beat changed while stalled");

    a_record_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready && (i_req_op == OP_RECORD) && (i_req_limit != '0)
        |=> i_res_valid && (i_res_data.kind == KIND_RECORD) && i_res_data.last)
        else $error("record beat missing its result");

    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (i_res_data.last == (i_res_data.kind != KIND_RESEND)))
        else $error("last flag does not match result kind");

    a_total_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_res_data.kind == KIND_DONE) |-> i_res_data.resend_total <= 6'(SLOTS))
        else $error("resend total beyond slot count");

endmodule

bind sack_retransmit_slot_tracker_top srst_checker u_srst_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_req_op    (i_req.data.operation),
    .i_req_limit (i_req.data.max_resends),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_data  (o_res.data)
);
